/* rtl/payload_protocol_classifier_defines.svh */
// Assertion macros shared by the classifier RTL.
// Depends on nothing; files that assert include it by name.
`ifndef PAYLOAD_PROTOCOL_CLASSIFIER_DEFINES_SVH
`define PAYLOAD_PROTOCOL_CLASSIFIER_DEFINES_SVH
`ifndef SYNTHESIS
// clocked check, disabled while reset is high
`define PPC_ASSERT(name, clk, rst, prop) \
   name: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("ppc assertion failed");
// clocked check that also holds through reset
`define PPC_ASSERT_ALWAYS(name, clk, prop) \
   name: assert property (@(posedge clk) prop) \
      else $error("ppc assertion failed");
`else
`define PPC_ASSERT(name, clk, rst, prop)
`define PPC_ASSERT_ALWAYS(name, clk, prop)
`endif
`endif

/* rtl/ppc_pkg.sv */
// Types, codes and prefix tables for the payload protocol classifier.
// No dependencies.
`default_nettype none

package ppc_pkg;

   localparam int DNS_HDR_LEN  = 12;
   localparam int NUM_METHODS  = 9;
   localparam int NUM_RESP     = 3;
   localparam int PREFIX_BYTES = 8;

   // protocol codes
   localparam logic [2:0] PROTO_UNKNOWN  = 3'd0;
   localparam logic [2:0] PROTO_HTTP_REQ = 3'd1;
   localparam logic [2:0] PROTO_HTTP_RSP = 3'd2;
   localparam logic [2:0] PROTO_TLS      = 3'd3;
   localparam logic [2:0] PROTO_DNS      = 3'd4;

   localparam logic [3:0] METHOD_NONE = 4'd0;

   localparam logic [7:0]  TLS_TYPE_MIN = 8'd20;
   localparam logic [7:0]  TLS_TYPE_MAX = 8'd23;
   localparam logic [7:0]  TLS_MAJOR    = 8'd3;
   localparam logic [15:0] TLS_MIN_LEN  = 16'd3;
   localparam logic [15:0] DNS_MIN_LEN  = 16'd12;
   localparam logic [15:0] COUNT_MAX    = 16'hFFFF;

   // CSR map: word address is paddr[2]
   localparam int          CSR_ADDR_W     = 3;
   localparam logic        REG_DNS_PORT   = 1'b0;
   localparam logic [15:0] DNS_PORT_RESET = 16'd53;

   typedef struct packed {
      logic [7:0]  data_byte;
      logic        last_byte;
      logic        is_udp;
      logic [15:0] src_port;
      logic [15:0] dst_port;
   } ppc_req_type;

   typedef struct packed {
      logic [2:0]  protocol;
      logic [3:0]  method;
      logic [15:0] byte_total;
      logic [15:0] dns_id;
      logic [15:0] dns_flags;
      logic [15:0] dns_questions;
      logic [15:0] dns_answers;
      logic [15:0] dns_authority;
      logic [15:0] dns_additional;
   } ppc_rsp_type;

   // byte i of the payload head is head[i]
   typedef logic [DNS_HDR_LEN-1:0][7:0] ppc_head_type;

   // finished payload handed from front to back
   typedef struct packed {
      ppc_head_type head;
      logic [15:0]  len;
      logic         is_udp;
      logic         port_match;
   } ppc_job_type;

   // text is right-aligned ASCII, first char in the highest used byte
   typedef struct packed {
      logic [8*PREFIX_BYTES-1:0] text;
      logic [3:0]                len;
   } ppc_prefix_type;

   localparam ppc_prefix_type METHOD_TAB [NUM_METHODS] = '{
      '{text: 64'("GET "),     len: 4'd4},
      '{text: 64'("POST "),    len: 4'd5},
      '{text: 64'("HEAD "),    len: 4'd5},
      '{text: 64'("PUT "),     len: 4'd4},
      '{text: 64'("DELETE "),  len: 4'd7},
      '{text: 64'("OPTIONS "), len: 4'd8},
      '{text: 64'("PATCH "),   len: 4'd6},
      '{text: 64'("CONNECT "), len: 4'd8},
      '{text: 64'("TRACE "),   len: 4'd6}
   };

   localparam ppc_prefix_type RESP_TAB [NUM_RESP] = '{
      '{text: 64'("HTTP/1.0"), len: 4'd8},
      '{text: 64'("HTTP/1.1"), len: 4'd8},
      '{text: 64'("HTTP/2"),   len: 4'd6}
   };

   // payload starts with the prefix and is at least as long
   function automatic logic prefix_hit(input ppc_head_type head, input logic [15:0] len,
                                       input ppc_prefix_type p);
      logic hit;
      int   k;
      hit = (len >= 16'(p.len));
      k   = 0;
      for (int j = 0; j < PREFIX_BYTES; j++) begin
         if (j < int'(p.len)) begin
            k = int'(p.len) - 1 - j;
            if (head[j] != p.text[k*8 +: 8]) begin
               hit = 1'b0;
            end
         end
      end
      return hit;
   endfunction

endpackage

`default_nettype wire

/* rtl/ppc_fifo.sv */
// Small register FIFO used for the job queue and the result queue.
// Depends on payload_protocol_classifier_defines.svh.
`default_nettype none
`include "payload_protocol_classifier_defines.svh"

module ppc_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] din,
   output logic                  full,
   input  wire logic             pop,
   output logic      [WIDTH-1:0] dout,
   output logic                  empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == CNT_W'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign dout    = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= din;
      end
   end

   `PPC_ASSERT(a_cnt_bound, clock, reset, count_ff <= CNT_W'(DEPTH))
   `PPC_ASSERT(a_push_fills, clock, reset, (do_push && !do_pop) |=> !empty)
   `PPC_ASSERT(a_pop_drains, clock, reset, (do_pop && !do_push) |=> !full)

endmodule

`default_nettype wire

/* rtl/ppc_front.sv */
// Front end: takes payload bytes, keeps the head bytes and the byte count,
// and emits one job per payload. Depends on ppc_pkg and the defines header.
`default_nettype none
`include "payload_protocol_classifier_defines.svh"

module ppc_front #(
   parameter int HEAD_DEPTH = 12
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                push,
   input  wire ppc_pkg::ppc_req_type req_data,
   output logic                     full,
   input  wire logic [15:0]         dns_port,
   output logic                     job_push,
   output ppc_pkg::ppc_job_type     job_data,
   input  wire logic                job_full
);
   import ppc_pkg::*;

   localparam int IDX_W = $clog2(HEAD_DEPTH);

   logic [7:0]  head_ff [HEAD_DEPTH];
   logic [15:0] count_ff, count_in;
   logic [15:0] count_inc;
   logic        accept;
   logic        store;

   // stall every byte while the job queue is full
   assign full      = job_full;
   assign accept    = push && !job_full;
   assign store     = accept && (count_ff < 16'(HEAD_DEPTH));
   assign count_inc = (count_ff == COUNT_MAX) ? count_ff : count_ff + 16'd1;
   assign job_push  = accept && req_data.last_byte;

   always_comb begin
      count_in = count_ff;
      if (accept) begin
         count_in = req_data.last_byte ? 16'd0 : count_inc;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (store) begin
         head_ff[count_ff[IDX_W-1:0]] <= req_data.data_byte;
      end
   end

   // head as it stands after this byte is written
   for (genvar i = 0; i < DNS_HDR_LEN; i++) begin : g_head
      assign job_data.head[i] = (count_ff == 16'(i)) ? req_data.data_byte : head_ff[i];
   end

   assign job_data.len        = count_inc;
   assign job_data.is_udp     = req_data.is_udp;
   assign job_data.port_match = (req_data.src_port == dns_port) ||
                                (req_data.dst_port == dns_port);

   `PPC_ASSERT(a_last_clears, clock, reset, (accept && req_data.last_byte) |=> count_ff == 16'd0)
   `PPC_ASSERT(a_mid_counts, clock, reset, (accept && !req_data.last_byte) |=> count_ff != 16'd0)
   `PPC_ASSERT(a_idle_holds, clock, reset, !accept |=> $stable(count_ff))

endmodule

`default_nettype wire

/* rtl/ppc_classify.sv */
// Back end: turns a finished payload job into one result.
// Depends on ppc_pkg.
`default_nettype none

module ppc_classify (
   input  wire ppc_pkg::ppc_job_type job,
   output ppc_pkg::ppc_rsp_type      rsp
);
   import ppc_pkg::*;

   logic [3:0] method;
   logic       resp_hit;
   logic       tls_hit;

   // first matching method wins
   always_comb begin
      method = METHOD_NONE;
      for (int i = NUM_METHODS - 1; i >= 0; i--) begin
         if (prefix_hit(job.head, job.len, METHOD_TAB[i])) begin
            method = 4'(i + 1);
         end
      end
   end

   always_comb begin
      resp_hit = 1'b0;
      for (int i = 0; i < NUM_RESP; i++) begin
         if (prefix_hit(job.head, job.len, RESP_TAB[i])) begin
            resp_hit = 1'b1;
         end
      end
   end

   assign tls_hit = (job.len >= TLS_MIN_LEN) && (job.head[0] >= TLS_TYPE_MIN) &&
                    (job.head[0] <= TLS_TYPE_MAX) && (job.head[1] == TLS_MAJOR);

   always_comb begin
      rsp            = '0;
      rsp.byte_total = job.len;
      if (!job.is_udp) begin
         if (method != METHOD_NONE) begin
            rsp.protocol = PROTO_HTTP_REQ;
            rsp.method   = method;
         end else if (resp_hit) begin
            rsp.protocol = PROTO_HTTP_RSP;
         end else if (tls_hit) begin
            rsp.protocol = PROTO_TLS;
         end
      end else if (job.len >= DNS_MIN_LEN && job.port_match) begin
         rsp.protocol       = PROTO_DNS;
         rsp.dns_id         = {job.head[0],  job.head[1]};
         rsp.dns_flags      = {job.head[2],  job.head[3]};
         rsp.dns_questions  = {job.head[4],  job.head[5]};
         rsp.dns_answers    = {job.head[6],  job.head[7]};
         rsp.dns_authority  = {job.head[8],  job.head[9]};
         rsp.dns_additional = {job.head[10], job.head[11]};
      end
   end

endmodule

`default_nettype wire

/* rtl/payload_protocol_classifier.sv */
// Top level of the payload protocol classifier: CSR, front end, job queue,
// classifier and result queue. Depends on ppc_pkg, ppc_front, ppc_fifo, ppc_classify.
`default_nettype none

// Payload bytes enter one per cycle on the push/full queue port, first byte
// first, last_byte set on the final one; is_udp and both ports are taken from
// the last byte. The front end stores the first HEAD_DEPTH bytes and a count
// that saturates at 65535, and on the last byte hands the payload head, length
// and a dns_port match flag to a JOB_DEPTH-entry job queue. The back end
// combinationally classifies the oldest job and writes the result into an
// RSP_DEPTH-entry result queue read through empty/pop. Throughput is one byte
// per cycle while full is low; a result passes through the job queue and
// then the result queue before it shows on rsp_data. full rises
// only when both queues back up behind a stalled pop, and then holds every
// byte, not only last bytes. dns_port (reset 53) sits at byte address 0 of
// the CSR port and should be written while no payload is in flight; pready
// is tied high.

module payload_protocol_classifier #(
   parameter int HEAD_DEPTH = 12,
   parameter int JOB_DEPTH  = 2,
   parameter int RSP_DEPTH  = 2
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   // input payload bytes
   input  wire logic                          push,
   input  wire ppc_pkg::ppc_req_type          req_data,
   output logic                               full,
   // results
   output logic                               empty,
   input  wire logic                          pop,
   output ppc_pkg::ppc_rsp_type               rsp_data,
   // CSR port
   input  wire logic                          psel,
   input  wire logic                          penable,
   input  wire logic                          pwrite,
   input  wire logic [ppc_pkg::CSR_ADDR_W-1:0] paddr,
   input  wire logic [31:0]                   pwdata,
   output logic      [31:0]                   prdata,
   output logic                               pready
);
   import ppc_pkg::*;

   logic [15:0] dns_port_ff, dns_port_in;
   logic        csr_wr;

   ppc_job_type job_in, job_out;
   logic        job_push, job_full, job_empty;
   logic        job_pop;
   ppc_rsp_type rsp_in;
   logic        rsp_full;

   // ---------------- CSR ----------------
   assign pready = 1'b1;
   // transfer lands on the access cycle; byte lanes within the word ignored
   assign csr_wr = psel && penable && pwrite && pready;

   always_comb begin
      dns_port_in = dns_port_ff;
      if (csr_wr && paddr[2] == REG_DNS_PORT) begin
         dns_port_in = pwdata[15:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dns_port_ff <= DNS_PORT_RESET;
      end else begin
         dns_port_ff <= dns_port_in;
      end
   end

   assign prdata = (paddr[2] == REG_DNS_PORT) ? {16'd0, dns_port_ff} : 32'd0;

   // ---------------- front end ----------------
   ppc_front #(
      .HEAD_DEPTH (HEAD_DEPTH)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .req_data (req_data),
      .full     (full),
      .dns_port (dns_port_ff),
      .job_push (job_push),
      .job_data (job_in),
      .job_full (job_full)
   );

   // ---------------- job queue ----------------
   // decouples byte intake from result drain
   ppc_fifo #(
      .WIDTH ($bits(ppc_job_type)),
      .DEPTH (JOB_DEPTH)
   ) u_job_q (
      .clock (clock),
      .reset (reset),
      .push  (job_push),
      .din   (job_in),
      .full  (job_full),
      .pop   (job_pop),
      .dout  (job_out),
      .empty (job_empty)
   );

   // ---------------- back end ----------------
   // one job classified per cycle whenever the result queue has room
   assign job_pop = !job_empty && !rsp_full;

   ppc_classify u_classify (
      .job (job_out),
      .rsp (rsp_in)
   );

   ppc_fifo #(
      .WIDTH ($bits(ppc_rsp_type)),
      .DEPTH (RSP_DEPTH)
   ) u_rsp_q (
      .clock (clock),
      .reset (reset),
      .push  (job_pop),
      .din   (rsp_in),
      .full  (rsp_full),
      .pop   (pop),
      .dout  (rsp_data),
      .empty (empty)
   );

endmodule

`default_nettype wire
